FILE: hw/rtl/twe_pkg.sv
// ----------------------------------------------------------------------------
// twe_pkg
// types, codes and fixed-point constants of the two-wheel drive core
// ----------------------------------------------------------------------------
package twe_pkg;

    localparam logic REQ_PIN  = 1'b0;
    localparam logic REQ_CTRL = 1'b1;

    localparam logic [2:0] MODE_STOP  = 3'd0;
    localparam logic [2:0] MODE_FWD   = 3'd1;
    localparam logic [2:0] MODE_REV   = 3'd2;
    localparam logic [2:0] MODE_RIGHT = 3'd3;
    localparam logic [2:0] MODE_LEFT  = 3'd4;

    localparam logic [2:0] REG_GP_L = 3'd0;
    localparam logic [2:0] REG_GI_L = 3'd1;
    localparam logic [2:0] REG_GD_L = 3'd2;
    localparam logic [2:0] REG_GP_R = 3'd3;
    localparam logic [2:0] REG_GI_R = 3'd4;
    localparam logic [2:0] REG_GD_R = 3'd5;
    localparam logic [2:0] REG_GOAL = 3'd6;
    localparam logic [2:0] REG_CAP  = 3'd7;

    localparam int ADDR_W = 5;

    // degrees = count * 768 / 7 = count * 109 + count * 5 / 7
    localparam int DEG_INT  = 109;
    localparam int DEG_FRAC = 5;
    localparam int DEG_DEN  = 7;
    localparam int RECIP_SH = 31;
    localparam longint RECIP7 = (longint'(1) << RECIP_SH) / DEG_DEN;
    localparam int DEG_SAT_COUNT = 19573419;
    localparam int TARGET_K = 5224259;
    localparam int DIST_K   = 210463;
    localparam logic [6:0] DUTY_MAX = 7'd100;

    typedef struct packed {
        logic       req_type;
        logic       pin_left_a;
        logic       pin_left_b;
        logic       pin_right_a;
        logic       pin_right_b;
        logic [2:0] drive_mode;
    } in_t;

    typedef struct packed {
        logic               left_fwd;
        logic               left_rev;
        logic               right_fwd;
        logic               right_rev;
        logic [6:0]         duty_left;
        logic [6:0]         duty_right;
        logic signed [31:0] travel_left;
        logic signed [31:0] travel_right;
        logic [30:0]        miss_left;
        logic [30:0]        miss_right;
    } out_t;

    typedef struct packed {
        logic       is_ctrl;
        logic [3:0] pins;
        logic [2:0] mode;
    } cmd_t;

    typedef struct packed {
        logic [15:0]        gp_l;
        logic [15:0]        gi_l;
        logic [15:0]        gd_l;
        logic [15:0]        gp_r;
        logic [15:0]        gi_r;
        logic [15:0]        gd_r;
        logic signed [23:0] goal;
        logic [6:0]         cap;
    } cfg_t;

endpackage

FILE: hw/rtl/twe_front.sv
// ----------------------------------------------------------------------------
// twe_front
// accepts input beats, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module twe_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  twe_pkg::in_t  s_data,
    output logic          q_valid,
    input  logic          q_ready,
    output twe_pkg::cmd_t q_cmd
);

    twe_pkg::cmd_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    twe_pkg::cmd_t cmd;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        cmd.is_ctrl = (s_data.req_type == twe_pkg::REQ_CTRL);
        cmd.pins    = {s_data.pin_right_b, s_data.pin_right_a,
                       s_data.pin_left_b, s_data.pin_left_a};
        cmd.mode    = s_data.drive_mode;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/twe_engine.sv
// ----------------------------------------------------------------------------
// twe_engine
// back end: quadrature decode, bridge outputs and the two pid loops on one
// shared multiplier
// ----------------------------------------------------------------------------
module twe_engine (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  twe_pkg::cmd_t q_cmd,
    input  twe_pkg::cfg_t cfg,
    output logic          m_valid,
    input  logic          m_ready,
    output twe_pkg::out_t m_data
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_TGT_MUL = 4'd1;
    localparam logic [3:0] ST_TGT     = 4'd2;
    localparam logic [3:0] ST_DEG_MUL = 4'd3;
    localparam logic [3:0] ST_DEG     = 4'd4;
    localparam logic [3:0] ST_ERR     = 4'd5;
    localparam logic [3:0] ST_MUL_P   = 4'd6;
    localparam logic [3:0] ST_MUL_I   = 4'd7;
    localparam logic [3:0] ST_MUL_D   = 4'd8;
    localparam logic [3:0] ST_ACC     = 4'd9;
    localparam logic [3:0] ST_DRV     = 4'd10;
    localparam logic [3:0] ST_DIST    = 4'd11;
    localparam logic [3:0] ST_DONE    = 4'd12;

    function automatic logic [31:0] decode(input logic [31:0] c, input logic oa,
                                           input logic ob, input logic na,
                                           input logic nb, input logic a_pos);
        logic ca, cb, up;
        ca = oa ^ na;
        cb = ob ^ nb;
        up = ((na == nb) ~^ a_pos) ^ cb;
        if (ca == cb) begin
            return c;
        end
        return up ? c + 32'd1 : c - 32'd1;
    endfunction

    function automatic logic [6:0] duty(input logic signed [31:0] d,
                                        input logic [6:0] cap);
        logic [32:0] a;
        a = d[31] ? -{d[31], d} : {1'b0, d};
        if (a[32:8] > {18'd0, cap}) begin
            return cap;
        end
        return a[14:8];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        if (v > 42'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -42'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [45:0] trunc20(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + (p[65] ? 66'sd1048575 : 66'sd0);
        return t[65:20];
    endfunction

    logic [3:0]  state_reg, state_next;
    logic        wheel_reg;
    logic [31:0] cnt_l_reg, cnt_r_reg;
    logic [3:0]  last_pins_reg;
    logic        seen_reg;
    logic signed [31:0] e1_l_reg, e2_l_reg, e1_r_reg, e2_r_reg;
    logic signed [31:0] drv_l_reg, drv_r_reg;
    logic signed [31:0] trav_l_reg, trav_r_reg;
    logic [30:0] miss_l_reg, miss_r_reg;
    logic signed [65:0] prod_reg;
    logic signed [52:0] acc_reg;
    logic signed [31:0] target_reg, deg_reg, e_reg;
    logic        neg_reg, sat_reg;
    logic [24:0] m_reg;
    logic [27:0] x_reg;
    twe_pkg::out_t res_reg, out_reg;
    twe_pkg::out_t res_new;
    logic        out_valid_reg;

    logic signed [35:0] mul_a;
    logic signed [29:0] mul_b;
    logic signed [65:0] mul_p;
    logic [31:0] cnt_sel;
    logic signed [31:0] e1_sel, e2_sel, drv_sel, cnt_s;
    logic [15:0] gp_sel, gi_sel, gd_sel;
    logic [32:0] cnt_abs;
    logic [24:0] m_new;
    logic [27:0] x_new;
    logic        sat_new;
    logic [25:0] q0, qv;
    logic [28:0] rem;
    logic [31:0] mag;
    logic signed [31:0] deg_new;
    logic signed [32:0] err_w;
    logic signed [31:0] e_new;
    logic signed [52:0] acc_t;
    logic signed [40:0] delta;
    logic signed [31:0] drv_new;
    logic signed [45:0] dist_w;
    logic signed [31:0] dist_cur;
    logic signed [32:0] miss_w;
    logic [32:0] miss_abs;
    logic [30:0] miss_new;
    logic [6:0]  cap;
    logic        load_out;

    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);

    always_comb begin
        cnt_sel = wheel_reg ? cnt_r_reg : cnt_l_reg;
        e1_sel  = wheel_reg ? e1_r_reg : e1_l_reg;
        e2_sel  = wheel_reg ? e2_r_reg : e2_l_reg;
        drv_sel = wheel_reg ? drv_r_reg : drv_l_reg;
        gp_sel  = wheel_reg ? cfg.gp_r : cfg.gp_l;
        gi_sel  = wheel_reg ? cfg.gi_r : cfg.gi_l;
        gd_sel  = wheel_reg ? cfg.gd_r : cfg.gd_l;
        cap     = (cfg.cap > twe_pkg::DUTY_MAX) ? twe_pkg::DUTY_MAX : cfg.cap;

        res_new = '0;
        if (q_cmd.mode == twe_pkg::MODE_FWD || q_cmd.mode == twe_pkg::MODE_REV ||
            q_cmd.mode == twe_pkg::MODE_RIGHT || q_cmd.mode == twe_pkg::MODE_LEFT) begin
            res_new.left_rev   = (q_cmd.mode == twe_pkg::MODE_REV);
            res_new.right_rev  = (q_cmd.mode == twe_pkg::MODE_REV);
            res_new.left_fwd   = (q_cmd.mode != twe_pkg::MODE_REV);
            res_new.right_fwd  = (q_cmd.mode != twe_pkg::MODE_REV);
            res_new.duty_left  = duty(drv_l_reg,
                (q_cmd.mode == twe_pkg::MODE_RIGHT) ? cap : twe_pkg::DUTY_MAX);
            res_new.duty_right = duty(drv_r_reg,
                (q_cmd.mode == twe_pkg::MODE_LEFT) ? cap : twe_pkg::DUTY_MAX);
        end

        cnt_s   = cnt_sel;
        cnt_abs = cnt_s[31] ? -{cnt_s[31], cnt_s} : {1'b0, cnt_s};
        sat_new = (cnt_s >= 32'(twe_pkg::DEG_SAT_COUNT)) ||
                  (cnt_s <= -32'(twe_pkg::DEG_SAT_COUNT));
        m_new   = cnt_abs[24:0];
        x_new   = 28'(m_new) * 28'(twe_pkg::DEG_FRAC);

        q0   = prod_reg[twe_pkg::RECIP_SH+25:twe_pkg::RECIP_SH];
        rem  = {1'b0, x_reg} - 29'(q0) * 29'(twe_pkg::DEG_DEN);
        qv   = (rem >= 29'(twe_pkg::DEG_DEN)) ? q0 + 26'd1 : q0;
        mag  = 32'(m_reg) * 32'(twe_pkg::DEG_INT) + 32'(qv);
        if (sat_reg) begin
            deg_new = neg_reg ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            deg_new = neg_reg ? -$signed(mag) : $signed(mag);
        end

        err_w = {target_reg[31], target_reg} - {deg_reg[31], deg_reg};
        e_new = sat32(42'(err_w));

        acc_t = acc_reg + (acc_reg[52] ? 53'sd4095 : 53'sd0);
        delta = acc_t[52:12];
        drv_new = sat32(42'(delta) + 42'(drv_sel));

        dist_w   = trunc20(prod_reg);
        dist_cur = dist_w[31:0];
        miss_w   = 33'(cfg.goal) - 33'(dist_cur);
        miss_abs = miss_w[32] ? -miss_w : miss_w;
        miss_new = (miss_abs > 33'h07fffffff) ? 31'h7fffffff : miss_abs[30:0];

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_TGT_MUL: begin
                mul_a = 36'(cfg.goal);
                mul_b = 30'(twe_pkg::TARGET_K);
            end
            ST_DEG_MUL: begin
                mul_a = $signed({8'd0, x_new});
                mul_b = 30'(twe_pkg::RECIP7);
            end
            ST_MUL_P: begin
                mul_a = 36'(e_reg) - 36'(e1_sel);
                mul_b = $signed({14'd0, gp_sel});
            end
            ST_MUL_I: begin
                mul_a = 36'(e_reg);
                mul_b = $signed({14'd0, gi_sel});
            end
            ST_MUL_D: begin
                mul_a = 36'(e_reg) - (36'(e1_sel) <<< 1) + 36'(e2_sel);
                mul_b = $signed({14'd0, gd_sel});
            end
            ST_DRV: begin
                mul_a = 36'(deg_reg);
                mul_b = 30'(twe_pkg::DIST_K);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 66'(mul_a) * 66'(mul_b);

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_cmd.is_ctrl) begin
                    state_next = (q_cmd.mode == twe_pkg::MODE_FWD) ? ST_TGT_MUL : ST_DONE;
                end
            end
            ST_TGT_MUL: state_next = ST_TGT;
            ST_TGT:     state_next = ST_DEG_MUL;
            ST_DEG_MUL: state_next = ST_DEG;
            ST_DEG:     state_next = ST_ERR;
            ST_ERR:     state_next = ST_MUL_P;
            ST_MUL_P:   state_next = ST_MUL_I;
            ST_MUL_I:   state_next = ST_MUL_D;
            ST_MUL_D:   state_next = ST_ACC;
            ST_ACC:     state_next = ST_DRV;
            ST_DRV:     state_next = ST_DIST;
            ST_DIST:    state_next = wheel_reg ? ST_DONE : ST_DEG_MUL;
            ST_DONE:    state_next = load_out ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        case (state_reg)
            ST_IDLE:  res_reg <= res_new;
            ST_TGT:   target_reg <= dist_w[31:0];
            ST_DEG_MUL: begin
                m_reg   <= m_new;
                x_reg   <= x_new;
                neg_reg <= cnt_s[31];
                sat_reg <= sat_new;
            end
            ST_DEG:   deg_reg <= deg_new;
            ST_ERR:   e_reg <= e_new;
            ST_MUL_I: acc_reg <= 53'(prod_reg);
            ST_MUL_D: acc_reg <= acc_reg + 53'(prod_reg);
            ST_ACC:   acc_reg <= acc_reg + 53'(prod_reg);
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wheel_reg     <= 1'b0;
            cnt_l_reg     <= '0;
            cnt_r_reg     <= '0;
            last_pins_reg <= '0;
            seen_reg      <= 1'b0;
            e1_l_reg      <= '0;
            e2_l_reg      <= '0;
            e1_r_reg      <= '0;
            e2_r_reg      <= '0;
            drv_l_reg     <= '0;
            drv_r_reg     <= '0;
            trav_l_reg    <= '0;
            trav_r_reg    <= '0;
            miss_l_reg    <= '0;
            miss_r_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && q_valid && !q_cmd.is_ctrl) begin
                if (seen_reg) begin
                    cnt_l_reg <= decode(cnt_l_reg, last_pins_reg[0], last_pins_reg[1],
                                        q_cmd.pins[0], q_cmd.pins[1], 1'b0);
                    cnt_r_reg <= decode(cnt_r_reg, last_pins_reg[2], last_pins_reg[3],
                                        q_cmd.pins[2], q_cmd.pins[3], 1'b1);
                end
                last_pins_reg <= q_cmd.pins;
                seen_reg      <= 1'b1;
            end
            if (state_reg == ST_TGT) begin
                wheel_reg <= 1'b0;
            end
            if (state_reg == ST_DRV) begin
                if (wheel_reg) begin
                    drv_r_reg <= drv_new;
                    e2_r_reg  <= e1_r_reg;
                    e1_r_reg  <= e_reg;
                end else begin
                    drv_l_reg <= drv_new;
                    e2_l_reg  <= e1_l_reg;
                    e1_l_reg  <= e_reg;
                end
            end
            if (state_reg == ST_DIST) begin
                wheel_reg <= 1'b1;
                if (wheel_reg) begin
                    trav_r_reg <= dist_cur;
                    miss_r_reg <= miss_new;
                end else begin
                    trav_l_reg <= dist_cur;
                    miss_l_reg <= miss_new;
                end
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
                out_reg       <= {res_reg.left_fwd, res_reg.left_rev,
                                  res_reg.right_fwd, res_reg.right_rev,
                                  res_reg.duty_left, res_reg.duty_right,
                                  trav_l_reg, trav_r_reg, miss_l_reg, miss_r_reg};
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/two_wheel_encoder_pid_drive_core.sv
// ----------------------------------------------------------------------------
// two_wheel_encoder_pid_drive_core
// two-wheel drive controller with x4 quadrature decode and per-wheel pid
//
// s_ channel: one beat is an encoder pin sample or a control step. pin samples
// update the wheel counts and give no result; each control step gives one m_
// beat with bridge levels, duties and the held travel and miss values.
// a two-beat queue sits between the input side and the execution sequencer.
// a pin sample is handled in the idle state, a non-forward control step goes
// straight to the done state and a forward step runs one target product, then
// nine steps per wheel through the single shared multiplier. results leave
// through an output register; while m_ready is low the sequencer holds its
// finished step and the queue keeps accepting until it is full.
// reset clears counts, errors, drives and held values and loads the default
// gains; the apb registers read back their values, pready is always high.
// ----------------------------------------------------------------------------
module two_wheel_encoder_pid_drive_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  twe_pkg::in_t               s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output twe_pkg::out_t              m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [twe_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    twe_pkg::cfg_t cfg_reg;
    logic          q_valid, q_ready;
    twe_pkg::cmd_t q_cmd;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[twe_pkg::ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gp_l <= 16'd3482;
            cfg_reg.gi_l <= 16'd0;
            cfg_reg.gd_l <= 16'd0;
            cfg_reg.gp_r <= 16'd4710;
            cfg_reg.gi_r <= 16'd0;
            cfg_reg.gd_r <= 16'd0;
            cfg_reg.goal <= 24'sd0;
            cfg_reg.cap  <= 7'd40;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                twe_pkg::REG_GP_L: cfg_reg.gp_l <= pwdata[15:0];
                twe_pkg::REG_GI_L: cfg_reg.gi_l <= pwdata[15:0];
                twe_pkg::REG_GD_L: cfg_reg.gd_l <= pwdata[15:0];
                twe_pkg::REG_GP_R: cfg_reg.gp_r <= pwdata[15:0];
                twe_pkg::REG_GI_R: cfg_reg.gi_r <= pwdata[15:0];
                twe_pkg::REG_GD_R: cfg_reg.gd_r <= pwdata[15:0];
                twe_pkg::REG_GOAL: cfg_reg.goal <= pwdata[23:0];
                twe_pkg::REG_CAP:  cfg_reg.cap  <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            twe_pkg::REG_GP_L: prdata = {16'd0, cfg_reg.gp_l};
            twe_pkg::REG_GI_L: prdata = {16'd0, cfg_reg.gi_l};
            twe_pkg::REG_GD_L: prdata = {16'd0, cfg_reg.gd_l};
            twe_pkg::REG_GP_R: prdata = {16'd0, cfg_reg.gp_r};
            twe_pkg::REG_GI_R: prdata = {16'd0, cfg_reg.gi_r};
            twe_pkg::REG_GD_R: prdata = {16'd0, cfg_reg.gd_r};
            twe_pkg::REG_GOAL: prdata = {8'd0, cfg_reg.goal};
            twe_pkg::REG_CAP:  prdata = {25'd0, cfg_reg.cap};
            default:           prdata = 32'd0;
        endcase
    end

    twe_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    twe_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .cfg     (cfg_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.duty_left <= twe_pkg::DUTY_MAX) &&
                    (m_data.duty_right <= twe_pkg::DUTY_MAX))
        else $error("duty above limit");

    a_bridge_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.left_fwd && m_data.left_rev) &&
                    !(m_data.right_fwd && m_data.right_rev))
        else $error("bridge driven both ways");

    a_stop_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.left_fwd && !m_data.left_rev) |->
            (m_data.duty_left == 7'd0) && (m_data.duty_right == 7'd0))
        else $error("duty on a stopped bridge");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

FILE: sim/drive_checker.sv
// ----------------------------------------------------------------------------
// drive_checker
// predicts the drive core's control-step results from the accepted input
// beats and the applied register values, and compares each m_ beat field by
// field with the oldest prediction
// ----------------------------------------------------------------------------
module drive_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  twe_pkg::in_t               s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  twe_pkg::out_t              m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [twe_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,
    output int                         fail_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PPT = 840;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    logic [15:0]        gp_l, gi_l, gd_l, gp_r, gi_r, gd_r;
    logic signed [23:0] goal_cfg;
    logic [6:0]         cap_cfg;
    logic [31:0]        cnt_l, cnt_r;
    logic [3:0]         pins_old;
    logic               pins_valid;
    longint             e1_l, e2_l, e1_r, e2_r, drv_l, drv_r;
    longint             trav_l, trav_r, miss_l, miss_r;
    twe_pkg::out_t      result_q[$];

    function automatic longint clamp32(longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    function automatic logic [31:0] quad_step(logic [31:0] c, logic oa, logic ob,
                                              logic na, logic nb, int a_rule);
        int s;
        if ((oa != na) == (ob != nb)) return c;
        s = (na == nb) ? a_rule : -a_rule;
        if (ob != nb) s = -s;
        return s > 0 ? c + 1 : c - 1;
    endfunction

    function automatic logic [6:0] duty_from(longint ctrl, longint lim);
        longint c;
        c = ctrl < 0 ? -ctrl : ctrl;
        c = c / 256;
        if (c > lim) c = lim;
        return c[6:0];
    endfunction

    task automatic wheel_update(input logic [31:0] cnt, input longint target,
                                input longint goal, input longint gp,
                                input longint gi, input longint gd,
                                inout longint e1, inout longint e2,
                                inout longint drv, output longint trav,
                                output longint miss);
        longint deg, e, d, m;
        deg = clamp32(longint'($signed(cnt)) * 92160 / PPT);
        e = clamp32(target - deg);
        d = gp * (e - e1) + gi * e + gd * (e - 2 * e1 + e2);
        drv = clamp32(drv + d / 4096);
        e2 = e1;
        e1 = e;
        trav = clamp32(deg * 210463 / 1048576);
        m = goal - trav;
        if (m < 0) m = -m;
        if (m > SAT_HI) m = SAT_HI;
        miss = m;
    endtask

    task automatic predict_beat(input twe_pkg::in_t b);
        twe_pkg::out_t r;
        longint cap, goal, target;
        logic [2:0] md;
        r = '0;
        if (b.req_type == twe_pkg::REQ_PIN) begin
            if (pins_valid) begin
                cnt_l = quad_step(cnt_l, pins_old[0], pins_old[1],
                                  b.pin_left_a, b.pin_left_b, -1);
                cnt_r = quad_step(cnt_r, pins_old[2], pins_old[3],
                                  b.pin_right_a, b.pin_right_b, 1);
            end
            pins_old = {b.pin_right_b, b.pin_right_a, b.pin_left_b, b.pin_left_a};
            pins_valid = 1'b1;
            return;
        end
        md = b.drive_mode;
        cap = cap_cfg > 100 ? 100 : cap_cfg;
        if (md == twe_pkg::MODE_FWD || md == twe_pkg::MODE_REV ||
            md == twe_pkg::MODE_RIGHT || md == twe_pkg::MODE_LEFT) begin
            if (md == twe_pkg::MODE_REV) begin
                r.left_rev = 1'b1;
                r.right_rev = 1'b1;
            end else begin
                r.left_fwd = 1'b1;
                r.right_fwd = 1'b1;
            end
            r.duty_left = duty_from(drv_l, md == twe_pkg::MODE_RIGHT ? cap : 100);
            r.duty_right = duty_from(drv_r, md == twe_pkg::MODE_LEFT ? cap : 100);
        end
        if (md == twe_pkg::MODE_FWD) begin
            goal = longint'(goal_cfg);
            target = goal * 5224259 / 1048576;
            wheel_update(cnt_l, target, goal, gp_l, gi_l, gd_l, e1_l, e2_l, drv_l,
                         trav_l, miss_l);
            wheel_update(cnt_r, target, goal, gp_r, gi_r, gd_r, e1_r, e2_r, drv_r,
                         trav_r, miss_r);
        end
        r.travel_left = trav_l[31:0];
        r.travel_right = trav_r[31:0];
        r.miss_left = miss_l[30:0];
        r.miss_right = miss_r[30:0];
        result_q.push_back(r);
    endtask

    assign pending = result_q.size();

    always @(posedge aclk) begin
        twe_pkg::out_t exp_r;
        if (!aresetn) begin
            gp_l <= 16'd3482; gi_l <= '0; gd_l <= '0;
            gp_r <= 16'd4710; gi_r <= '0; gd_r <= '0;
            goal_cfg <= '0; cap_cfg <= 7'd40;
            cnt_l = '0; cnt_r = '0; pins_old = '0; pins_valid = 1'b0;
            e1_l = 0; e2_l = 0; e1_r = 0; e2_r = 0; drv_l = 0; drv_r = 0;
            trav_l = 0; trav_r = 0; miss_l = 0; miss_r = 0;
            fail_count <= 0;
            result_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    twe_pkg::REG_GP_L: gp_l <= pwdata[15:0];
                    twe_pkg::REG_GI_L: gi_l <= pwdata[15:0];
                    twe_pkg::REG_GD_L: gd_l <= pwdata[15:0];
                    twe_pkg::REG_GP_R: gp_r <= pwdata[15:0];
                    twe_pkg::REG_GI_R: gi_r <= pwdata[15:0];
                    twe_pkg::REG_GD_R: gd_r <= pwdata[15:0];
                    twe_pkg::REG_GOAL: goal_cfg <= pwdata[23:0];
                    twe_pkg::REG_CAP:  cap_cfg <= pwdata[6:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat %h", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = result_q.pop_front();
                    if (exp_r !== m_data) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h actual %h", exp_r, m_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                predict_beat(s_data);
        end
    end
endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// random and directed stimulus for the two-wheel drive core: quadrature
// pin sequences and control steps in all modes, several register settings,
// random idling on both channels and one long output hold-off
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    twe_pkg::in_t               s_data = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    twe_pkg::out_t              m_data;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [twe_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;
    int                         fail_count;
    int                         pending;
    int                         idle_cycles = 0;
    bit                         sink_hold = 1'b0;
    logic [3:0]                 cur_pins = '0;

    always #5 aclk = ~aclk;

    two_wheel_encoder_pid_drive_core u_top (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    drive_checker u_chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
    );

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int g;
        forever begin
            @(negedge aclk);
            if (sink_hold) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                sink_hold = 1'b0;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input twe_pkg::in_t b, input bit allow_gap);
        int g;
        g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_pins(input logic [3:0] p);
        twe_pkg::in_t b;
        b = '0;
        b.req_type = twe_pkg::REQ_PIN;
        {b.pin_right_b, b.pin_right_a, b.pin_left_b, b.pin_left_a} = p;
        b.drive_mode = 3'($urandom_range(0, 7));
        cur_pins = p;
        send_beat(b, 1'b1);
    endtask

    task automatic send_step(input logic [2:0] md);
        twe_pkg::in_t b;
        b = '0;
        b.req_type = twe_pkg::REQ_CTRL;
        {b.pin_right_b, b.pin_right_a, b.pin_left_b, b.pin_left_a} = 4'($urandom);
        b.drive_mode = md;
        send_beat(b, 1'b1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= twe_pkg::ADDR_W'({idx, 2'b00}); pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [3:0] gray_next(logic [3:0] p, bit rev_l, bit rev_r);
        logic [1:0] l, r;
        l = p[1:0];
        r = p[3:2];
        l = rev_l ? {l[0], ~l[1]} : {~l[0], l[1]};
        r = rev_r ? {r[0], ~r[1]} : {~r[0], r[1]};
        if ($urandom_range(0, 3) == 0) l = p[1:0];
        if ($urandom_range(0, 3) == 0) r = p[3:2];
        return {r, l};
    endfunction

    task automatic random_phase(input int n);
        bit rl, rr;
        int k;
        rl = $urandom_range(0, 1);
        rr = $urandom_range(0, 1);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 29) == 0) begin
                rl = ~rl;
                rr = $urandom_range(0, 1);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_pins(gray_next(cur_pins, rl, rr));
                5: send_pins(4'($urandom));
                6, 7: send_step(twe_pkg::MODE_FWD);
                default: send_step(3'($urandom_range(0, 7)));
            endcase
        end
    endtask

    initial begin
        int k;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_step(twe_pkg::MODE_FWD);
        send_pins(4'b0000);
        send_pins(4'b0001);
        send_pins(4'b0011);
        send_pins(4'b0010);
        send_pins(4'b0110);
        send_pins(4'b1110);
        send_pins(4'b1101);
        send_pins(4'b1111);
        send_pins(4'b0101);
        send_step(twe_pkg::MODE_FWD);
        send_step(twe_pkg::MODE_STOP);
        send_step(twe_pkg::MODE_REV);
        send_step(twe_pkg::MODE_RIGHT);
        send_step(twe_pkg::MODE_LEFT);
        send_step(3'd5);
        send_step(3'd6);
        send_step(3'd7);
        drain();

        reg_write(twe_pkg::REG_GP_L, 32'hFFFF);
        reg_write(twe_pkg::REG_GI_L, 32'h0400);
        reg_write(twe_pkg::REG_GD_L, 32'h0800);
        reg_write(twe_pkg::REG_GP_R, 32'h0000);
        reg_write(twe_pkg::REG_GI_R, 32'hFFFF);
        reg_write(twe_pkg::REG_GD_R, 32'hFFFF);
        reg_write(twe_pkg::REG_GOAL, 32'h007FFFFF);
        reg_write(twe_pkg::REG_CAP, 32'd127);
        for (k = 0; k < 6; k++) send_step(twe_pkg::MODE_FWD);
        send_step(twe_pkg::MODE_RIGHT);
        send_step(twe_pkg::MODE_LEFT);
        drain();

        reg_write(twe_pkg::REG_GOAL, 32'h00800000);
        reg_write(twe_pkg::REG_CAP, 32'd0);
        sink_hold = 1'b1;
        random_phase(250);
        drain();

        for (k = 0; k < 3; k++) begin
            reg_write(twe_pkg::REG_GP_L, $urandom_range(0, 65535));
            reg_write(twe_pkg::REG_GI_L, $urandom_range(0, 2000));
            reg_write(twe_pkg::REG_GD_L, $urandom_range(0, 65535));
            reg_write(twe_pkg::REG_GP_R, $urandom_range(0, 65535));
            reg_write(twe_pkg::REG_GI_R, $urandom_range(0, 2000));
            reg_write(twe_pkg::REG_GD_R, $urandom_range(0, 65535));
            reg_write(twe_pkg::REG_GOAL, $urandom);
            reg_write(twe_pkg::REG_CAP, $urandom_range(0, 127));
            random_phase(230);
            drain();
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/twe_pkg.sv
hw/rtl/twe_front.sv
hw/rtl/twe_engine.sv
hw/rtl/two_wheel_encoder_pid_drive_core.sv
sim/drive_checker.sv
sim/testbench.sv
